[design/mtfq_pkg.sv]
// ----------------------------------------------------------------------------
// mtfq_pkg: shared types for the move-to-front queue
// Queue depth, command and status codes, and the structs passed from the
// input stage to the queue core and back.
// ----------------------------------------------------------------------------
package mtfq_pkg;

  localparam int unsigned Depth   = 16;
  localparam int unsigned IdxW    = $clog2(Depth);
  localparam int unsigned CntW    = $clog2(Depth + 1);
  localparam int unsigned DataW   = 32;
  localparam int unsigned PosW    = 4;
  localparam int unsigned OccW    = 5;
  localparam int unsigned InTdataW  = ((DataW + PosW + 7) / 8) * 8;
  localparam int unsigned OutTdataW = ((DataW + OccW + 7) / 8) * 8;

  typedef enum logic [1:0] {
    CMD_ENQ,
    CMD_DEQ,
    CMD_MTF
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_EMPTY,
    ST_FULL,
    ST_RANGE
  } status_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [DataW-1:0]  data_in;
    logic [PosW-1:0]   position;
  } item_t;

  typedef struct packed {
    logic [DataW-1:0]  data_out;
    status_e           status;
    logic [OccW-1:0]   occupancy;
  } result_t;

endpackage

[design/move_to_front_queue.sv]
// ----------------------------------------------------------------------------
// move_to_front_queue: bounded FIFO with move-to-front
//
//   channel  dir  tdata (low bit up)                    tuser
//   s_axis   in   data_in[31:0], position[35:32], pad    cmd[1:0]
//   m_axis   out  data_out[31:0], occupancy[36:32], pad  status[1:0]
//
// One command per cycle while m_axis keeps up: a transfer lands in the input register, the core
// updates all slots in one pass, and the result sits in the output register.
// An s_axis transfer reaches m_axis valid through the input register and then the output register.
// Reset empties the queue at once; slot contents are not cleared.
// A stalled m_axis holds the result and the input register backs up.
// ----------------------------------------------------------------------------
module move_to_front_queue (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [mtfq_pkg::InTdataW-1:0]     s_axis_tdata,  // data_in, position
  input  logic [1:0]                        s_axis_tuser,  // cmd
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [mtfq_pkg::OutTdataW-1:0]    m_axis_tdata,  // data_out, occupancy
  output logic [1:0]                        m_axis_tuser   // status
);

  logic              in_valid_q, out_valid_q, advance;
  mtfq_pkg::item_t   item_q;
  mtfq_pkg::result_t res_d, res_q;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q.cmd      <= mtfq_pkg::cmd_e'(s_axis_tuser);
      item_q.data_in  <= s_axis_tdata[mtfq_pkg::DataW-1:0];
      item_q.position <= s_axis_tdata[mtfq_pkg::DataW +: mtfq_pkg::PosW];
    end
    if (advance) res_q <= res_d;
  end

  mtfq_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .apply_i  (advance),
    .item_i   (item_q),
    .result_o (res_d)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.status;
  assign m_axis_tdata  = {{(mtfq_pkg::OutTdataW - mtfq_pkg::DataW - mtfq_pkg::OccW){1'b0}},
                          res_q.occupancy, res_q.data_out};

  a_ready_when_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled with output register free");

  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result lost after advance");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> 32'(res_q.occupancy) <= mtfq_pkg::Depth)
    else $error("occupancy beyond depth");

endmodule

[design/mtfq_core.sv]
// ----------------------------------------------------------------------------
// mtfq_core: slot array and fill count
// Applies one command per cycle, when apply_i is set, through per-slot muxes and forms its result.
// ----------------------------------------------------------------------------
module mtfq_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              apply_i,
  input  mtfq_pkg::item_t   item_i,
  output mtfq_pkg::result_t result_o
);

  logic [mtfq_pkg::DataW-1:0] slots_q [mtfq_pkg::Depth];
  logic [mtfq_pkg::DataW-1:0] slots_d [mtfq_pkg::Depth];
  logic [mtfq_pkg::CntW-1:0]  fill_q, fill_d;

  logic                       is_full, is_empty, pos_bad;
  logic [mtfq_pkg::IdxW-1:0]  pos_idx;
  logic [mtfq_pkg::DataW-1:0] moved;

  assign is_full  = (32'(fill_q) >= mtfq_pkg::Depth);
  assign is_empty = (fill_q == '0);
  assign pos_bad  = (32'(item_i.position) >= 32'(fill_q)) ||
                    (32'(item_i.position) >= mtfq_pkg::Depth);
  assign pos_idx  = mtfq_pkg::IdxW'(item_i.position);
  assign moved    = slots_q[pos_idx];

  always_comb begin
    fill_d            = fill_q;
    result_o.data_out = '0;
    result_o.status   = mtfq_pkg::ST_OK;
    for (int unsigned i = 0; i < mtfq_pkg::Depth; i++) begin
      slots_d[i] = slots_q[i];
    end
    case (item_i.cmd)
      mtfq_pkg::CMD_ENQ: begin
        if (is_full) begin
          result_o.status = mtfq_pkg::ST_FULL;
        end else begin
          for (int unsigned i = 0; i < mtfq_pkg::Depth; i++) begin
            if (32'(fill_q) == i) slots_d[i] = item_i.data_in;
          end
          fill_d = fill_q + 1'b1;
        end
      end
      mtfq_pkg::CMD_DEQ: begin
        if (is_empty) begin
          result_o.data_out = '1;
          result_o.status   = mtfq_pkg::ST_EMPTY;
        end else begin
          result_o.data_out = slots_q[0];
          for (int unsigned i = 0; i + 1 < mtfq_pkg::Depth; i++) begin
            slots_d[i] = slots_q[i+1];
          end
          fill_d = fill_q - 1'b1;
        end
      end
      mtfq_pkg::CMD_MTF: begin
        if (pos_bad) begin
          result_o.status = mtfq_pkg::ST_RANGE;
        end else if (item_i.position != '0) begin
          slots_d[0] = moved;
          for (int unsigned i = 1; i < mtfq_pkg::Depth; i++) begin
            if (i <= 32'(item_i.position)) slots_d[i] = slots_q[i-1];
          end
        end
      end
      default: begin
      end
    endcase
    result_o.occupancy = mtfq_pkg::OccW'(fill_d);
  end

  always_ff @(posedge clk_i) begin
    if (apply_i) begin
      for (int unsigned i = 0; i < mtfq_pkg::Depth; i++) begin
        slots_q[i] <= slots_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (apply_i) begin
      fill_q <= fill_d;
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= mtfq_pkg::Depth)
    else $error("fill count beyond depth");

  a_deq_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    apply_i && item_i.cmd == mtfq_pkg::CMD_DEQ && fill_q != '0
    |=> fill_q == $past(fill_q) - 1'b1)
    else $error("dequeue did not drop count");

  a_mtf_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    apply_i && item_i.cmd == mtfq_pkg::CMD_MTF |=> $stable(fill_q))
    else $error("move-to-front changed count");

  a_empty_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    apply_i && result_o.status == mtfq_pkg::ST_EMPTY |-> &result_o.data_out)
    else $error("empty dequeue data not all ones");

endmodule

[test/move_to_front_queue_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// move_to_front_queue_test: self-checking bench for the move-to-front queue
// Drives commands on s_axis, captures results on m_axis and compares each
// one with a behavioral copy of the queue kept in the bench, or with the
// table's values. A short table covers empty, full, range and position-zero
// cases; random traffic follows with fill, drain and balanced phases, random
// idling on both sides and one long m_axis hold-off that backs the block up.
// ----------------------------------------------------------------------------
module move_to_front_queue_test;

  localparam logic [1:0]  CmdUnused  = 2'd3;
  localparam logic [31:0] EmptyData  = 32'hFFFF_FFFF;
  localparam int          NumRandom  = 1000;
  localparam int          NumSteps   = 28;
  localparam int          HoldCycles = 300;
  localparam int          DrainWait  = 8;
  localparam int          Limit      = 500000;

  typedef struct {
    logic [1:0]        cmd;
    logic [31:0]       din;
    logic [3:0]        pos;
    bit                typed;
    logic [31:0]       w_data;
    mtfq_pkg::status_e w_status;
    logic [4:0]        w_occ;
  } step_t;

  step_t dir_steps [NumSteps] = '{
    '{mtfq_pkg::CMD_DEQ, 32'h0000_0000, 4'd0,  1'b1, EmptyData, mtfq_pkg::ST_EMPTY, 5'd0},
    '{mtfq_pkg::CMD_MTF, 32'h0000_0000, 4'd0,  1'b1, 32'h0,     mtfq_pkg::ST_RANGE, 5'd0},
    '{CmdUnused,         32'hFFFF_FFFF, 4'd15, 1'b1, 32'h0,     mtfq_pkg::ST_OK,    5'd0},
    '{mtfq_pkg::CMD_ENQ, 32'h7FFF_FFFF, 4'd0,  1'b1, 32'h0,     mtfq_pkg::ST_OK,    5'd1},
    '{mtfq_pkg::CMD_ENQ, 32'h8000_0000, 4'd15, 1'b1, 32'h0,     mtfq_pkg::ST_OK,    5'd2},
    '{mtfq_pkg::CMD_ENQ, 32'hFFFF_FFFF, 4'd0,  1'b1, 32'h0,     mtfq_pkg::ST_OK,    5'd3},
    '{mtfq_pkg::CMD_ENQ, 32'h0000_0000, 4'd0,  1'b1, 32'h0,     mtfq_pkg::ST_OK,    5'd4},
    '{mtfq_pkg::CMD_MTF, 32'h0000_0000, 4'd0,  1'b1, 32'h0,     mtfq_pkg::ST_OK,    5'd4},
    '{mtfq_pkg::CMD_MTF, 32'hFFFF_FFFF, 4'd3,  1'b0, 32'h0,     mtfq_pkg::ST_OK,    5'd0},
    '{mtfq_pkg::CMD_MTF, 32'h0000_0000, 4'd4,  1'b1, 32'h0,     mtfq_pkg::ST_RANGE, 5'd4},
    '{mtfq_pkg::CMD_MTF, 32'h0000_0000, 4'd15, 1'b1, 32'h0,     mtfq_pkg::ST_RANGE, 5'd4},
    '{mtfq_pkg::CMD_DEQ, 32'h0000_0000, 4'd0,  1'b0, 32'h0,     mtfq_pkg::ST_OK,    5'd0},
    '{mtfq_pkg::CMD_ENQ, 32'h0000_0001, 4'd0,  1'b0, 32'h0,     mtfq_pkg::ST_OK,    5'd0},
    '{mtfq_pkg::CMD_ENQ, 32'hFFFF_FFFE, 4'd0,  1'b0, 32'h0,     mtfq_pkg::ST_OK,    5'd0},
    '{mtfq_pkg::CMD_ENQ, 32'h1234_5678, 4'd0,  1'b0, 32'h0,     mtfq_pkg::ST_OK,    5'd0},
    '{mtfq_pkg::CMD_ENQ, 32'h8765_4321, 4'd0,  1'b0, 32'h0,     mtfq_pkg::ST_OK,    5'd0},
    '{mtfq_pkg::CMD_ENQ, 32'hA5A5_A5A5, 4'd0,  1'b0, 32'h0,     mtfq_pkg::ST_OK,    5'd0},
    '{mtfq_pkg::CMD_ENQ, 32'h5A5A_5A5A, 4'd0,  1'b0, 32'h0,     mtfq_pkg::ST_OK,    5'd0},
    '{mtfq_pkg::CMD_ENQ, 32'h0000_FFFF, 4'd0,  1'b0, 32'h0,     mtfq_pkg::ST_OK,    5'd0},
    '{mtfq_pkg::CMD_ENQ, 32'hFFFF_0000, 4'd0,  1'b0, 32'h0,     mtfq_pkg::ST_OK,    5'd0},
    '{mtfq_pkg::CMD_ENQ, 32'h0F0F_0F0F, 4'd0,  1'b0, 32'h0,     mtfq_pkg::ST_OK,    5'd0},
    '{mtfq_pkg::CMD_ENQ, 32'hF0F0_F0F0, 4'd0,  1'b0, 32'h0,     mtfq_pkg::ST_OK,    5'd0},
    '{mtfq_pkg::CMD_ENQ, 32'h7FFF_FFFE, 4'd0,  1'b0, 32'h0,     mtfq_pkg::ST_OK,    5'd0},
    '{mtfq_pkg::CMD_ENQ, 32'h8000_0001, 4'd0,  1'b0, 32'h0,     mtfq_pkg::ST_OK,    5'd0},
    '{mtfq_pkg::CMD_ENQ, 32'hDEAD_BEEF, 4'd0,  1'b0, 32'h0,     mtfq_pkg::ST_OK,    5'd0},
    '{mtfq_pkg::CMD_ENQ, 32'h1111_1111, 4'd0,  1'b1, 32'h0,     mtfq_pkg::ST_FULL,  5'd16},
    '{mtfq_pkg::CMD_MTF, 32'h0000_0000, 4'd15, 1'b0, 32'h0,     mtfq_pkg::ST_OK,    5'd0},
    '{mtfq_pkg::CMD_DEQ, 32'h0000_0000, 4'd0,  1'b0, 32'h0,     mtfq_pkg::ST_OK,    5'd0}
  };

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [mtfq_pkg::InTdataW-1:0]  s_axis_tdata  = '0;   // data_in, position
  logic [1:0]                     s_axis_tuser  = '0;   // cmd
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [mtfq_pkg::OutTdataW-1:0] m_axis_tdata;         // data_out, occupancy
  logic [1:0]                     m_axis_tuser;         // status

  logic [31:0]        mtf_slots [mtfq_pkg::Depth];
  int unsigned        mtf_count = 0;
  mtfq_pkg::result_t  pending_q [$];
  mtfq_pkg::result_t  got, want;
  int                 err_count = 0;
  int                 items_sent = 0;
  int                 cycles = 0;

  move_to_front_queue u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  function automatic mtfq_pkg::result_t mtf_apply(logic [1:0] cmd, logic [31:0] din,
                                                  logic [3:0] pos);
    mtfq_pkg::result_t r;
    logic [31:0]       moved;
    r.data_out = '0;
    r.status   = mtfq_pkg::ST_OK;
    case (cmd)
      mtfq_pkg::CMD_ENQ: begin
        if (mtf_count >= mtfq_pkg::Depth) begin
          r.status = mtfq_pkg::ST_FULL;
        end else begin
          mtf_slots[mtf_count] = din;
          mtf_count++;
        end
      end
      mtfq_pkg::CMD_DEQ: begin
        if (mtf_count == 0) begin
          r.data_out = EmptyData;
          r.status   = mtfq_pkg::ST_EMPTY;
        end else begin
          r.data_out = mtf_slots[0];
          for (int i = 1; i < mtf_count; i++) mtf_slots[i-1] = mtf_slots[i];
          mtf_count--;
        end
      end
      mtfq_pkg::CMD_MTF: begin
        if (pos >= mtf_count) begin
          r.status = mtfq_pkg::ST_RANGE;
        end else if (pos != 0) begin
          moved = mtf_slots[pos];
          for (int i = pos; i > 0; i--) mtf_slots[i] = mtf_slots[i-1];
          mtf_slots[0] = moved;
        end
      end
      default: ;
    endcase
    r.occupancy = mtfq_pkg::OccW'(mtf_count);
    return r;
  endfunction

  function automatic int unsigned gap_len(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_cmd(input logic [1:0] cmd, input logic [31:0] din, input logic [3:0] pos);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= mtfq_pkg::InTdataW'({pos, din});
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic sender_gap(input bit calm);
    int unsigned g;
    g = gap_len(calm);
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic report(input string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > Limit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.data_out  = m_axis_tdata[mtfq_pkg::DataW-1:0];
      got.occupancy = m_axis_tdata[mtfq_pkg::DataW +: mtfq_pkg::OccW];
      got.status    = mtfq_pkg::status_e'(m_axis_tuser);
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result: data %h status %0d occ %0d",
                         got.data_out, got.status, got.occupancy));
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          report($sformatf({"mismatch: want data %h status %0d occ %0d, ",
                            "got data %h status %0d occ %0d"},
                           want.data_out, want.status, want.occupancy,
                           got.data_out, got.status, got.occupancy));
        end
      end
    end
  end

  // m_axis backpressure, with one long hold-off once traffic is under way
  initial begin : receiver
    int unsigned run;
    int unsigned g;
    bit          held;
    held = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held && items_sent >= 300) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
      repeat (run) @(posedge clk_i);
      g = gap_len(1'b0);
      if (g > 0) begin
        m_axis_tready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    mtfq_pkg::result_t res;
    logic [1:0]        cmd;
    logic [31:0]       din;
    logic [3:0]        pos;
    bit                calm;
    int unsigned       mode, r, enq_w, deq_w;
    calm = 1'b0;
    mode = 2;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (dir_steps[k]) begin
      send_cmd(dir_steps[k].cmd, dir_steps[k].din, dir_steps[k].pos);
      res = mtf_apply(dir_steps[k].cmd, dir_steps[k].din, dir_steps[k].pos);
      if (dir_steps[k].typed) begin
        res.data_out  = dir_steps[k].w_data;
        res.status    = dir_steps[k].w_status;
        res.occupancy = dir_steps[k].w_occ;
      end
      pending_q.push_back(res);
      sender_gap(1'b0);
    end

    for (int n = 0; n < NumRandom; n++) begin
      if (n % 50 == 0) begin
        mode = $urandom_range(0, 2);
        calm = ($urandom_range(0, 4) == 0);
      end
      case (mode)
        0:       begin enq_w = 60; deq_w = 15; end
        1:       begin enq_w = 15; deq_w = 60; end
        default: begin enq_w = 35; deq_w = 35; end
      endcase
      r = $urandom_range(0, 99);
      if (r < 2)                  cmd = CmdUnused;
      else if (r < 2 + enq_w)     cmd = mtfq_pkg::CMD_ENQ;
      else if (r < 2 + enq_w + deq_w) cmd = mtfq_pkg::CMD_DEQ;
      else                        cmd = mtfq_pkg::CMD_MTF;
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0:       din = 32'h0000_0000;
          1:       din = 32'h7FFF_FFFF;
          2:       din = 32'h8000_0000;
          default: din = 32'hFFFF_FFFF;
        endcase
      end else begin
        din = $urandom;
      end
      if (mtf_count > 0 && $urandom_range(0, 9) < 8) pos = 4'($urandom_range(0, mtf_count - 1));
      else pos = 4'($urandom_range(0, 15));
      send_cmd(cmd, din, pos);
      pending_q.push_back(mtf_apply(cmd, din, pos));
      sender_gap(calm);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (err_count == 0 && pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
